FILE: design/lowest_free_slot_allocator_assert.svh
// Assertion macros for the lowest free slot allocator.
// Used by the top level; expects clk and rst in scope.
`ifndef LOWEST_FREE_SLOT_ALLOCATOR_ASSERT_SVH
`define LOWEST_FREE_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define LFSA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lfsa_pkg.sv
// Shared types, codes and widths for the lowest free slot allocator.
// No dependencies.
`default_nettype none

package lfsa_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int ID_COUNT_DEF   = 1024;

  localparam int CFG_W       = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam int ID_IN_W     = 10;
  localparam int IN_TDATA_W  = 16;

  localparam int OUT_SLOT_W  = 6;
  localparam int USE_W       = 11;
  localparam int OUT_USES_LO = OUT_SLOT_W;
  localparam int OUT_TDATA_W = 24;
  localparam logic [USE_W-1:0] USE_MAX = 11'd2047;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DEPART = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_REJECTED = 2'd1,
    ST_RELEASED = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  typedef struct packed {
    logic clear_en;
    logic load_item;
    logic load_slot;
    logic commit;
  } lfsa_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_busy;
  } lfsa_stat_t;

endpackage

`default_nettype wire

FILE: design/lfsa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module lfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: design/lfsa_ctrl.sv
// Sequencer for the allocator: clearing sweep, then accept/read/commit per item.
// Depends on lfsa_pkg.
`default_nettype none

module lfsa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire lfsa_pkg::lfsa_stat_t sts,
  output lfsa_pkg::lfsa_cmd_t      ctl
);

  import lfsa_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_HOLD  = 4'b0100,
    S_COUNT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ctl.clear_en = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.load_item = 1'b1;
          state_next    = S_HOLD;
        end
      end
      S_HOLD: begin
        ctl.load_slot = 1'b1;
        state_next    = S_COUNT;
      end
      S_COUNT: begin
        if (!sts.out_busy) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/lfsa_dp.sv
// Allocator datapath: free map, priority pick, id map and usage counter RAMs,
// output register. Depends on lfsa_pkg and lfsa_ram.
`default_nettype none

module lfsa_dp #(
  parameter int SLOT_COUNT = lfsa_pkg::SLOT_COUNT_DEF,
  parameter int ID_COUNT   = lfsa_pkg::ID_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire lfsa_pkg::lfsa_cmd_t              ctl,
  output lfsa_pkg::lfsa_stat_t                  sts,
  input  wire logic                             cfg_wr_en,
  input  wire logic [lfsa_pkg::CFG_W-1:0]       cfg_wr_data,
  input  wire logic                             in_cmd,
  input  wire logic [lfsa_pkg::ID_IN_W-1:0]     in_id,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [1:0]                            m_tuser,
  output logic [lfsa_pkg::OUT_TDATA_W-1:0]      m_tdata
);

  import lfsa_pkg::*;

  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int HELD_W    = $clog2(SLOT_COUNT + 1);
  localparam int ID_W      = $clog2(ID_COUNT);
  localparam int CLR_DEPTH = (ID_COUNT > SLOT_COUNT) ? ID_COUNT : SLOT_COUNT;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  logic [CFG_W-1:0]      slots_cfg;
  logic [SLOT_COUNT-1:0] free_map;
  logic [SLOT_COUNT-1:0] avail;
  logic                  grant_found;
  logic [SLOT_W-1:0]     grant_slot;
  logic [CLR_W-1:0]      clr_cnt;

  logic                  cur_cmd;
  logic [ID_IN_W-1:0]    cur_id;
  logic                  id_ok;
  logic                  g_found;
  logic [SLOT_W-1:0]     g_slot;
  logic                  tgt_ok;
  logic [SLOT_W-1:0]     tgt_slot;

  logic                  held_we;
  logic [ID_W-1:0]       held_waddr;
  logic [HELD_W-1:0]     held_wdata;
  logic [ID_W-1:0]       held_raddr;
  logic [HELD_W-1:0]     held_rdata;
  logic [HELD_W-1:0]     held_m1;

  logic                  use_we;
  logic [SLOT_W-1:0]     use_waddr;
  logic [USE_W-1:0]      use_wdata;
  logic [SLOT_W-1:0]     use_raddr;
  logic [USE_W-1:0]      use_rdata;
  logic [USE_W-1:0]      uses_inc;

  logic [SLOT_W-1:0]     slot_sel;
  logic                  arrive;
  status_t               status_next;
  logic [USE_W-1:0]      uses_out;

  // lowest free slot below the configured count
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      avail[i] = free_map[i] & (32'(i) < 32'(slots_cfg));
    end
    grant_found = 1'b0;
    grant_slot  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (avail[i]) begin
        grant_found = 1'b1;
        grant_slot  = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_cfg <= CFG_RESET;
    end else if (cfg_wr_en) begin
      slots_cfg <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clear_en) begin
      clr_cnt <= clr_cnt + CLR_W'(1);
    end
  end

  assign sts.clear_done = (clr_cnt == CLR_W'(CLR_DEPTH - 1));
  assign sts.out_busy   = m_tvalid & ~m_tready;

  assign arrive   = (cur_cmd == CMD_ARRIVE);
  assign held_m1  = held_rdata - HELD_W'(1);
  assign slot_sel = arrive ? g_slot : held_m1[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cur_cmd <= in_cmd;
      cur_id  <= in_id;
      id_ok   <= (32'(in_id) < 32'(ID_COUNT));
      g_found <= grant_found;
      g_slot  <= grant_slot;
    end
    if (ctl.load_slot) begin
      tgt_slot <= slot_sel;
      tgt_ok   <= id_ok & (arrive ? g_found : (held_rdata != '0));
    end
  end

  // id map: 0 = none, else slot + 1
  assign held_raddr = ctl.load_item ? ID_W'(in_id) : ID_W'(cur_id);
  assign held_we    = ctl.clear_en | (ctl.commit & tgt_ok);
  assign held_waddr = ctl.clear_en ? ID_W'(clr_cnt) : ID_W'(cur_id);
  assign held_wdata = (ctl.clear_en || !arrive) ? '0 : HELD_W'(tgt_slot) + HELD_W'(1);

  lfsa_ram #(
    .WIDTH (HELD_W),
    .DEPTH (ID_COUNT)
  ) u_held_ram (
    .clk     (clk),
    .wr_en   (held_we),
    .wr_addr (held_waddr),
    .wr_data (held_wdata),
    .rd_addr (held_raddr),
    .rd_data (held_rdata)
  );

  assign uses_inc  = (use_rdata == USE_MAX) ? use_rdata : use_rdata + USE_W'(1);
  assign use_raddr = ctl.load_slot ? slot_sel : tgt_slot;
  assign use_we    = ctl.clear_en | (ctl.commit & tgt_ok & arrive);
  assign use_waddr = ctl.clear_en ? SLOT_W'(clr_cnt) : tgt_slot;
  assign use_wdata = ctl.clear_en ? '0 : uses_inc;

  lfsa_ram #(
    .WIDTH (USE_W),
    .DEPTH (SLOT_COUNT)
  ) u_use_ram (
    .clk     (clk),
    .wr_en   (use_we),
    .wr_addr (use_waddr),
    .wr_data (use_wdata),
    .rd_addr (use_raddr),
    .rd_data (use_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
    end else if (ctl.commit && tgt_ok) begin
      free_map[tgt_slot] <= !arrive;
    end
  end

  always_comb begin
    if (arrive) begin
      status_next = tgt_ok ? ST_GRANTED : ST_REJECTED;
      uses_out    = tgt_ok ? uses_inc : '0;
    end else begin
      status_next = tgt_ok ? ST_RELEASED : ST_IGNORED;
      uses_out    = tgt_ok ? use_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      m_tuser <= status_next;
      m_tdata <= {(OUT_TDATA_W - USE_W - OUT_SLOT_W)'(0), uses_out,
                  (tgt_ok ? OUT_SLOT_W'(tgt_slot) : OUT_SLOT_W'(0))};
    end
  end

endmodule

`default_nettype wire

FILE: design/lowest_free_slot_allocator.sv
// Channel   Signals                        Contents (low bit up)
// s_*       s_tvalid s_tready s_tuser      tuser: cmd; tdata: requester_id, zero pad
// m_*       m_tvalid m_tready m_tuser      tuser: status; tdata: slot, slot_uses, pad
// cfg_*     cfg_wr_en cfg_wr_data          slots_in_use
//
// An item goes through accept with id map read, then counter read, then commit.
// Its result is registered at the commit, behind the two registered RAM reads
// in series; the commit waits while the output register is full.
// After reset a clearing sweep over max(ID_COUNT, SLOT_COUNT) addresses (1024 by
// default) zeroes both RAMs with s_tready low; cfg writes are taken throughout.
// A result waits in the output register; the next item is accepted meanwhile
// and holds before its commit until the register drains.
// Depends on lfsa_pkg, lfsa_ctrl, lfsa_dp, lfsa_ram.
`default_nettype none
`include "lowest_free_slot_allocator_assert.svh"

module lowest_free_slot_allocator #(
  parameter int SLOT_COUNT = lfsa_pkg::SLOT_COUNT_DEF,
  parameter int ID_COUNT   = lfsa_pkg::ID_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lfsa_pkg::CFG_W-1:0]        cfg_wr_data,  // slots_in_use
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic                              s_tuser,      // cmd
  input  wire logic [lfsa_pkg::IN_TDATA_W-1:0]   s_tdata,      // requester_id[9:0]
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [1:0]                             m_tuser,      // status
  output logic [lfsa_pkg::OUT_TDATA_W-1:0]       m_tdata       // slot[5:0], slot_uses[16:6]
);

  import lfsa_pkg::*;

  lfsa_cmd_t  ctl;
  lfsa_stat_t sts;

  lfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lfsa_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .ID_COUNT   (ID_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (s_tuser),
    .in_id       (s_tdata[ID_IN_W-1:0]),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tuser     (m_tuser),
    .m_tdata     (m_tdata)
  );

  `LFSA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second item accepted while one in flight")
  `LFSA_ASSERT_IMPL(a_grant_counted, m_tvalid && m_tuser == ST_GRANTED, m_tdata[OUT_USES_LO +: USE_W] != '0, "grant with zero usage count")
  `LFSA_ASSERT_IMPL(a_fail_zero, m_tvalid && (m_tuser == ST_REJECTED || m_tuser == ST_IGNORED), m_tdata == '0, "failed event carries nonzero slot data")

endmodule

`default_nettype wire
